[sv/two_pointer_move_cost_dp_assert.svh]
// assertion macros for the move cost block
`ifndef TWO_POINTER_MOVE_COST_DP_ASSERT_SVH
`define TWO_POINTER_MOVE_COST_DP_ASSERT_SVH

`define TPM_ASSERT_IMPL(label, clk_i, rst_ni, a_i, c_i) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a_i) |-> (c_i)) \
    else $error("assertion failed");

`define TPM_ASSERT_NEXT(label, clk_i, rst_ni, a_i, c_i) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a_i) |=> (c_i)) \
    else $error("assertion failed");

`endif

[sv/tpmc_pkg.sv]
package tpmc_pkg;
  localparam int POSITIONS = 1024;
  localparam int AW = $clog2(POSITIONS + 1);
  localparam int PW = 11;
  localparam int CW = 64;
  localparam logic signed [CW-1:0] SENTINEL = 64'sh07ff_ffff_ffff_ffff;
  localparam logic signed [CW-1:0] NEG_SENTINEL = -SENTINEL;
  localparam logic [39:0] SUM_MAX = 40'hff_ffff_ffff;
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_FIRST = 2'd1;
  localparam logic [1:0] CFG_SECOND = 2'd2;
  localparam logic [1:0] SEL_COST = 2'd0;
  localparam logic [1:0] SEL_PRE = 2'd1;
  localparam logic [1:0] SEL_SUF = 2'd2;
  localparam logic [1:0] SEL_ALL = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SEED, ST_PREP, ST_QP_RD, ST_QP_WT, ST_QS_RD, ST_QS_WT,
    ST_COMB, ST_RLX_RD, ST_RLX_WT, ST_UP_RD, ST_UP_WT, ST_US_RD, ST_US_WT, ST_OUT
  } state_t;

  typedef struct packed {
    logic we;
    logic [1:0] sel;
    logic [AW-1:0] addr;
    logic signed [CW-1:0] wdata;
  } mem_req_t;

  function automatic logic [AW:0] low_bit(input logic [AW:0] x);
    return x & (~x + 1'b1);
  endfunction
endpackage

[sv/tpmc_store.sv]
module tpmc_store (
  input  logic clk,
  input  tpmc_pkg::mem_req_t req,
  output logic signed [tpmc_pkg::CW-1:0] rdata
);
  import tpmc_pkg::*;
  logic signed [CW-1:0] cost_mem [POSITIONS+1];
  logic signed [CW-1:0] pre_mem [POSITIONS+1];
  logic signed [CW-1:0] suf_mem [POSITIONS+1];
  logic [1:0] sel_r;
  logic signed [CW-1:0] c_r, p_r, s_r;

  always_ff @(posedge clk) begin
    if (req.we && req.sel == SEL_COST) cost_mem[req.addr] <= req.wdata;
    if (req.we && req.sel == SEL_PRE) pre_mem[req.addr] <= req.wdata;
    if (req.we && req.sel == SEL_SUF) suf_mem[req.addr] <= req.wdata;
    if (req.we && req.sel == SEL_ALL) begin
      cost_mem[req.addr] <= req.wdata;
      pre_mem[req.addr] <= req.wdata;
      suf_mem[req.addr] <= req.wdata;
    end
    c_r <= cost_mem[req.addr];
    p_r <= pre_mem[req.addr];
    s_r <= suf_mem[req.addr];
    sel_r <= req.sel;
  end

  always_comb begin
    unique case (sel_r)
      SEL_PRE: rdata = p_r;
      SEL_SUF: rdata = s_r;
      default: rdata = c_r;
    endcase
  end
endmodule

[sv/two_pointer_move_cost_dp.sv]
// throughput: one target at a time; busy stays high until the result beat
// a new_run item adds a clearing pass over addresses 0 to POSITIONS and a seed walk
// after reset a clearing pass over addresses 0 to POSITIONS runs with busy high
// the result beat is shown for one cycle; the receiver cannot stall
module two_pointer_move_cost_dp (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_new_run,
  input  logic [10:0] in_target,
  output logic out_valid,
  output logic [39:0] out_total_cost,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_data
);
  import tpmc_pkg::*;
  `include "two_pointer_move_cost_dp_assert.svh"

  state_t st_r, st_nxt;
  logic [PW-1:0] cnt_r, sf_r, ss_r, prev_r;
  logic [AW:0] clr_r, clr_nxt;
  logic [AW:0] p_r, p_nxt;
  logic [PW-1:0] a_r, a_nxt, b_r, b_nxt, d_r, d_nxt, rpos_r, rpos_nxt, prev_nxt;
  logic nr_r, nr_nxt, seed_r, seed_nxt, have_r, have_nxt;
  logic signed [CW-1:0] m_r, m_nxt, qa_r, qa_nxt, x_r, x_nxt, best_r, best_nxt;
  logic [39:0] sum_r, sum_nxt, tot_r, tot_nxt;
  logic ov_r, ov_nxt;
  logic signed [CW-1:0] rdata;
  mem_req_t req;
  logic [PW-1:0] n, tb, pa, fa;
  logic signed [CW+1:0] t64, tsum;
  logic [40:0] s41;

  tpmc_store u_store (.clk(clk), .req(req), .rdata(rdata));

  always_comb begin
    n = (cnt_r < 11'd1) ? 11'd1 : ((cnt_r > 11'(POSITIONS)) ? 11'(POSITIONS) : cnt_r);
    tb = (in_target < 11'd1) ? 11'd1 : ((in_target > n) ? n : in_target);
    pa = (prev_r < 11'd1) ? 11'd1 : ((prev_r > n) ? n : prev_r);
    fa = (sf_r < 11'd1) ? 11'd1 : ((sf_r > n) ? n : sf_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; cnt_r <= 11'd1024; sf_r <= 11'd1; ss_r <= 11'd1;
      prev_r <= 11'd1; clr_r <= '0; sum_r <= '0; best_r <= SENTINEL; ov_r <= 1'b0;
      nr_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; prev_r <= prev_nxt; sum_r <= sum_nxt;
      best_r <= best_nxt; ov_r <= ov_nxt; nr_r <= nr_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COUNT: cnt_r <= cfg_data;
          CFG_FIRST: sf_r <= cfg_data;
          CFG_SECOND: ss_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; a_r <= a_nxt; b_r <= b_nxt; d_r <= d_nxt; rpos_r <= rpos_nxt;
    seed_r <= seed_nxt; have_r <= have_nxt; m_r <= m_nxt;
    qa_r <= qa_nxt; x_r <= x_nxt; tot_r <= tot_nxt;
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; p_nxt = p_r; a_nxt = a_r; b_nxt = b_r;
    d_nxt = d_r; rpos_nxt = rpos_r; nr_nxt = nr_r; seed_nxt = seed_r;
    have_nxt = have_r; m_nxt = m_r; qa_nxt = qa_r; x_nxt = x_r; tot_nxt = tot_r;
    prev_nxt = prev_r; sum_nxt = sum_r; best_nxt = best_r; ov_nxt = 1'b0;
    req = '{we: 1'b0, sel: SEL_COST, addr: AW'(p_r), wdata: SENTINEL};
    t64 = '0; tsum = '0; s41 = '0;
    unique case (st_r)
      ST_CLEAR: begin
        req = '{we: 1'b1, sel: SEL_ALL, addr: AW'(clr_r), wdata: SENTINEL};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(POSITIONS)) st_nxt = nr_r ? ST_SEED : ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          nr_nxt = in_new_run; b_nxt = tb;
          if (in_new_run) begin
            clr_nxt = '0; st_nxt = ST_CLEAR; sum_nxt = '0; best_nxt = SENTINEL;
            prev_nxt = ss_r;
          end else st_nxt = ST_PREP;
        end
      end
      ST_SEED: begin
        nr_nxt = 1'b0; seed_nxt = 1'b1; rpos_nxt = fa; x_nxt = '0;
        p_nxt = (AW+1)'(fa); st_nxt = ST_RLX_RD;
      end
      ST_PREP: begin
        seed_nxt = 1'b0; a_nxt = pa; prev_nxt = b_r;
        d_nxt = (pa > b_r) ? pa - b_r : b_r - pa;
        s41 = {1'b0, sum_r} + 41'((pa > b_r) ? pa - b_r : b_r - pa);
        sum_nxt = s41[40] ? SUM_MAX : s41[39:0];
        m_nxt = SENTINEL; p_nxt = (AW+1)'(b_r); st_nxt = ST_QP_RD;
      end
      ST_QP_RD: begin
        if (p_r == '0) begin
          qa_nxt = m_r; m_nxt = SENTINEL; p_nxt = (AW+1)'(b_r); st_nxt = ST_QS_RD;
        end else begin
          req.sel = SEL_PRE; st_nxt = ST_QP_WT;
        end
      end
      ST_QP_WT: begin
        if (rdata < m_r) m_nxt = rdata;
        p_nxt = p_r - low_bit(p_r); st_nxt = ST_QP_RD;
      end
      ST_QS_RD: begin
        if (p_r == '0 || p_r > (AW+1)'(n)) st_nxt = ST_COMB;
        else begin
          req.sel = SEL_SUF; st_nxt = ST_QS_WT;
        end
      end
      ST_QS_WT: begin
        if (rdata < m_r) m_nxt = rdata;
        p_nxt = p_r + low_bit(p_r); st_nxt = ST_QS_RD;
      end
      ST_COMB: begin
        have_nxt = 1'b0; t64 = '0;
        if (qa_r < SENTINEL) begin
          t64 = (CW+2)'(qa_r) + (CW+2)'(b_r); have_nxt = 1'b1;
        end
        if (m_r < SENTINEL) begin
          tsum = (CW+2)'(m_r) - (CW+2)'(b_r);
          if (!(qa_r < SENTINEL) || tsum < t64) t64 = tsum;
          have_nxt = 1'b1;
        end
        tsum = t64 - (CW+2)'(d_r);
        x_nxt = (tsum < (CW+2)'(NEG_SENTINEL)) ? NEG_SENTINEL : CW'(tsum);
        rpos_nxt = a_r; p_nxt = (AW+1)'(a_r);
        st_nxt = (qa_r < SENTINEL || m_r < SENTINEL) ? ST_RLX_RD : ST_OUT;
      end
      ST_RLX_RD: begin
        req.sel = SEL_COST; st_nxt = ST_RLX_WT;
      end
      ST_RLX_WT: begin
        if (x_r < rdata) begin
          req = '{we: 1'b1, sel: SEL_COST, addr: AW'(rpos_r), wdata: x_r};
          if (x_r < best_r) best_nxt = x_r;
          st_nxt = ST_UP_RD;
        end else st_nxt = seed_r ? ST_PREP : ST_OUT;
      end
      ST_UP_RD: begin
        if (p_r == '0 || p_r > (AW+1)'(n)) begin
          p_nxt = (AW+1)'(rpos_r); st_nxt = ST_US_RD;
        end else begin
          req.sel = SEL_PRE; st_nxt = ST_UP_WT;
        end
      end
      ST_UP_WT: begin
        tsum = (CW+2)'(x_r) - (CW+2)'(rpos_r);
        if (CW'(tsum) < rdata) req = '{we: 1'b1, sel: SEL_PRE, addr: AW'(p_r), wdata: CW'(tsum)};
        p_nxt = p_r + low_bit(p_r); st_nxt = ST_UP_RD;
      end
      ST_US_RD: begin
        if (p_r == '0) st_nxt = seed_r ? ST_PREP : ST_OUT;
        else begin
          req.sel = SEL_SUF; st_nxt = ST_US_WT;
        end
      end
      ST_US_WT: begin
        tsum = (CW+2)'(x_r) + (CW+2)'(rpos_r);
        if (CW'(tsum) < rdata) req = '{we: 1'b1, sel: SEL_SUF, addr: AW'(p_r), wdata: CW'(tsum)};
        p_nxt = p_r - low_bit(p_r); st_nxt = ST_US_RD;
      end
      ST_OUT: begin
        if (best_r >= SENTINEL) tot_nxt = SUM_MAX;
        else begin
          tsum = (CW+2)'(best_r) + (CW+2)'(sum_r);
          if (tsum < 0) tot_nxt = '0;
          else if (tsum > (CW+2)'(SUM_MAX)) tot_nxt = SUM_MAX;
          else tot_nxt = tsum[39:0];
        end
        ov_nxt = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_total_cost = tot_r;

  `TPM_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `TPM_ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, st_r == ST_IDLE)
  `TPM_ASSERT_NEXT(a_out_pulse, clk, rst_n, out_valid, !out_valid)
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tpmc_pkg::*;

  typedef struct {
    logic        new_run;
    logic [10:0] target;
  } move_req_t;

  localparam longint EMPTY_COST = SENTINEL;
  localparam longint SUM_LIMIT = 64'h00ff_ffff_ffff;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_new_run = 1'b0;
  logic [10:0] in_target = '0;
  logic out_valid;
  logic [39:0] out_total_cost;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_COUNT;
  logic [10:0] cfg_data = '0;

  move_req_t pending_moves[$];
  logic [39:0] expected_costs[$];
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;

  // predictor state
  longint cost_tab[0:POSITIONS];
  longint pmin_tree[0:POSITIONS];
  longint smin_tree[0:POSITIONS];
  int unsigned prev_pos;
  longint dist_sum;
  longint best;
  logic [10:0] count_reg, first_reg, second_reg;

  two_pointer_move_cost_dp uut (.*);

  always #10 clk = ~clk;

  function automatic int unsigned lowbit(int unsigned x);
    return x & (~x + 1);
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned n);
    if (v < 1) return 1;
    if (v > n) return n;
    return v;
  endfunction

  function automatic int unsigned used_count();
    if (count_reg < 1) return 1;
    if (count_reg > POSITIONS) return POSITIONS;
    return count_reg;
  endfunction

  function automatic void wipe_tables();
    for (int i = 0; i <= POSITIONS; i++) begin
      cost_tab[i] = EMPTY_COST;
      pmin_tree[i] = EMPTY_COST;
      smin_tree[i] = EMPTY_COST;
    end
  endfunction

  function automatic void lower_cost(int unsigned pos, longint x, int unsigned n);
    int unsigned p;
    longint lo, hi;
    if (!(x < cost_tab[pos])) return;
    cost_tab[pos] = x;
    if (x < best) best = x;
    lo = x - longint'(pos);
    hi = x + longint'(pos);
    p = pos;
    while (p >= 1 && p <= n) begin
      if (lo < pmin_tree[p]) pmin_tree[p] = lo;
      p += lowbit(p);
    end
    p = pos;
    while (p != 0) begin
      if (hi < smin_tree[p]) smin_tree[p] = hi;
      p -= lowbit(p);
    end
  endfunction

  function automatic logic [39:0] predict_cost(logic new_run, logic [10:0] target);
    int unsigned n, a, b, d, p;
    longint qa, qb, m, x, total;
    bit have;
    n = used_count();
    have = 0;
    if (new_run) begin
      wipe_tables();
      dist_sum = 0;
      best = EMPTY_COST;
      prev_pos = second_reg;
      lower_cost(clamp_to(first_reg, n), 0, n);
    end
    a = clamp_to(prev_pos, n);
    b = clamp_to(target, n);
    prev_pos = b;
    d = (a > b) ? a - b : b - a;
    dist_sum += longint'(d);
    if (dist_sum > SUM_LIMIT) dist_sum = SUM_LIMIT;
    qa = EMPTY_COST;
    p = b;
    while (p != 0) begin
      if (pmin_tree[p] < qa) qa = pmin_tree[p];
      p -= lowbit(p);
    end
    qb = EMPTY_COST;
    p = b;
    while (p >= 1 && p <= n) begin
      if (smin_tree[p] < qb) qb = smin_tree[p];
      p += lowbit(p);
    end
    m = EMPTY_COST;
    if (qa < EMPTY_COST) begin
      m = qa + longint'(b);
      have = 1;
    end
    if (qb < EMPTY_COST) begin
      if (!have || qb - longint'(b) < m) m = qb - longint'(b);
      have = 1;
    end
    if (have) begin
      x = m - longint'(d);
      if (x < -EMPTY_COST) x = -EMPTY_COST;
      lower_cost(a, x, n);
    end
    if (best >= EMPTY_COST) begin
      total = SUM_LIMIT;
    end else begin
      total = best + dist_sum;
      if (total < 0) total = 0;
      if (total > SUM_LIMIT) total = SUM_LIMIT;
    end
    return total[39:0];
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
    end else begin
      if (start) expected_costs.push_back(predict_cost(in_new_run, in_target));
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_moves.size() > 0) begin
        move_req_t m;
        m = pending_moves.pop_front();
        in_new_run <= m.new_run;
        in_target <= m.target;
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1: gap_left = $urandom_range(1, 3);
          2: gap_left = $urandom_range(5, 40);
          default: gap_left = 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_costs.size() == 0) report_mismatch("unexpected beat", out_total_cost, '0);
      else begin
        logic [39:0] want;
        want = expected_costs.pop_front();
        if (out_total_cost !== want) report_mismatch("total_cost", out_total_cost, want);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_COUNT: count_reg = val;
      CFG_FIRST: first_reg = val;
      default: second_reg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_moves.size() > 0 || expected_costs.size() > 0 || start || busy)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic add_move(logic new_run, logic [10:0] target);
    move_req_t m;
    m.new_run = new_run;
    m.target = target;
    pending_moves.push_back(m);
  endtask

  task automatic random_phase(int items, logic [10:0] cnt, logic [10:0] f, logic [10:0] s);
    int unsigned n;
    wait_idle();
    write_reg(CFG_COUNT, cnt);
    write_reg(CFG_FIRST, f);
    write_reg(CFG_SECOND, s);
    n = used_count();
    for (int i = 0; i < items; i++) begin
      logic [10:0] t;
      if ($urandom_range(0, 9) == 0) t = 11'($urandom_range(0, 2047));
      else t = 11'($urandom_range(0, n + 1));
      add_move(i == 0 || $urandom_range(0, 39) == 0, t);
    end
  endtask

  initial begin
    count_reg = 11'd1024;
    first_reg = 11'd1;
    second_reg = 11'd1;
    wipe_tables();
    prev_pos = 1;
    dist_sum = 0;
    best = EMPTY_COST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // no cost seeded yet
    add_move(1'b0, 11'd5);
    add_move(1'b0, 11'd2047);
    add_move(1'b0, 11'd0);
    add_move(1'b1, 11'd1);
    add_move(1'b0, 11'd1024);
    add_move(1'b0, 11'd1);
    add_move(1'b0, 11'd2047);
    add_move(1'b0, 11'd0);
    add_move(1'b0, 11'd512);
    add_move(1'b1, 11'd1024);
    add_move(1'b0, 11'd1023);
    add_move(1'b0, 11'd2);
    wait_idle();
    write_reg(CFG_COUNT, 11'd1);
    add_move(1'b0, 11'd7);
    add_move(1'b1, 11'd1);
    add_move(1'b0, 11'd2047);
    wait_idle();
    write_reg(CFG_COUNT, 11'd2047);
    write_reg(CFG_FIRST, 11'd2047);
    write_reg(CFG_SECOND, 11'd0);
    // start registers only take effect on the next new run
    add_move(1'b0, 11'd3);
    add_move(1'b1, 11'd1024);
    add_move(1'b0, 11'd0);
    wait_idle();
    write_reg(CFG_COUNT, 11'd1024);
    random_phase(150, 11'd1024, 11'd1, 11'd1024);
    random_phase(120, 11'd8, 11'd3, 11'd6);
    random_phase(100, 11'd2, 11'd2, 11'd1);
    random_phase(120, 11'd0, 11'd0, 11'd2047);
    random_phase(150, 11'd2047, 11'd1365, 11'd682);
    random_phase(150, 11'd16, 11'd1, 11'd16);
    random_phase(150, 11'($urandom_range(1, 64)), 11'($urandom_range(0, 2047)),
                 11'($urandom_range(0, 2047)));
    wait_idle();
    repeat (60) @(posedge clk);
    if (expected_costs.size() != 0) begin
      $display("%0d results never arrived", expected_costs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
